// ===== design/sfe_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfe_pkg
// types, constants and register codes shared by the feature extractor
// ---------------------------------------------------------------------------
package sfe_pkg;

  localparam int WindowDepth = 5;
  localparam int SlotW = $clog2(WindowDepth);
  localparam int CountW = $clog2(WindowDepth + 1);
  localparam int AddrW = 5;

  localparam logic [AddrW-3:0] REG_RAW_MODE = 3'd0;
  localparam logic [AddrW-3:0] REG_TEMP_BOUNDS = 3'd1;
  localparam logic [AddrW-3:0] REG_HUM_BOUNDS = 3'd2;
  localparam logic [AddrW-3:0] REG_DTEMP_BOUNDS = 3'd3;
  localparam logic [AddrW-3:0] REG_DHUM_BOUNDS = 3'd4;
  localparam logic [AddrW-3:0] REG_MEAN_BOUNDS = 3'd5;
  localparam logic [AddrW-3:0] REG_SDEV_BOUNDS = 3'd6;

  localparam logic [31:0] TEMP_BOUNDS_RST = 32'd382600668;
  localparam logic [31:0] HUM_BOUNDS_RST = 32'd622592566;
  localparam logic [31:0] DTEMP_BOUNDS_RST = 32'd90241688;
  localparam logic [31:0] DHUM_BOUNDS_RST = 32'd221639300;
  localparam logic [31:0] MEAN_BOUNDS_RST = 32'd378471937;
  localparam logic [31:0] SDEV_BOUNDS_RST = 32'd112001024;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_VAR,
    ST_DIV_MEAN,
    ST_DIV_VAR,
    ST_SQRT,
    ST_SCALE_SETUP,
    ST_SCALE_DIV,
    ST_SCALE_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [40:0] num;
    logic [40:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [40:0] quo;
    logic [40:0] rem;
  } div_rsp_t;

endpackage

// ===== design/sfe_divider.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfe_divider
// shared restoring divider, one quotient bit per cycle, unsigned
// ---------------------------------------------------------------------------
module sfe_divider import sfe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [40:0] quo;
  logic [40:0] rem;
  logic [40:0] den;
  logic [5:0] cnt;
  logic busy;
  logic done;
  logic [41:0] trial;

  assign trial = {rem, quo[40]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd41;
        quo <= req.num;
        rem <= '0;
        den <= req.den;
      end else if (busy) begin
        if (!trial[41]) begin
          rem <= trial[40:0];
          quo <= {quo[39:0], 1'b1};
        end else begin
          rem <= {rem[39:0], quo[40]};
          quo <= {quo[39:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quo: quo, rem: rem};

endmodule

// ===== design/sensor_feature_extractor.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sensor_feature_extractor
// rolling mean, deviation and min-max scaling of temperature and humidity
// ---------------------------------------------------------------------------
// flow: accumulate the filled window entries (1 to 5), form n*sumsq - sum^2, divide for
// mean and variance, take the square root, then scale each feature by a division;
// a feature with empty bounds skips its division; up to eight divisions share the divider
// a new item is taken only once the previous result has been accepted
// raw mode: result valid in the cycle after the item is taken
// reset: synchronous, clears control state, history and registers to defaults
// ---------------------------------------------------------------------------
module sensor_feature_extractor import sfe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,   // temperature[14:0], humidity[28:15], zero pad
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [95:0]       m_tdata,   // norm_temperature, norm_humidity, norm_delta_temp,
                                       // norm_delta_humidity, norm_mean_temp,
                                       // norm_stddev_temp, 16 bits each
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic raw_mode;
  logic [31:0] bounds [6];
  logic signed [15:0] window [WindowDepth];
  logic [SlotW-1:0] write_slot;
  logic [CountW-1:0] filled_count;
  logic signed [15:0] prev_temperature;
  logic signed [15:0] prev_humidity;
  logic have_previous;

  state_t state, state_next;
  logic signed [15:0] t_in, h_in;
  logic signed [40:0] acc_sum;
  logic [40:0] acc_sq;
  logic [CountW-1:0] idx;
  logic signed [17:0] mul_a;
  logic signed [35:0] mul_p;
  logic [33:0] n_sumsq;
  logic [2*CountW-1:0] n_sq;
  logic signed [40:0] mean;
  logic [40:0] sq_x, sq_r, sq_bit;
  logic [2:0] feat;
  logic signed [16:0] feat_v [6];
  logic signed [15:0] res [6];
  logic neg;
  logic signed [40:0] snum;
  logic [40:0] sden;
  logic raw_out;
  div_req_t dreq;
  div_rsp_t drsp;

  logic cfg_wr;
  logic [AddrW-3:0] reg_idx;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode <= 1'b0;
      bounds[0] <= TEMP_BOUNDS_RST;
      bounds[1] <= HUM_BOUNDS_RST;
      bounds[2] <= DTEMP_BOUNDS_RST;
      bounds[3] <= DHUM_BOUNDS_RST;
      bounds[4] <= MEAN_BOUNDS_RST;
      bounds[5] <= SDEV_BOUNDS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RAW_MODE: raw_mode <= pwdata[0];
        REG_TEMP_BOUNDS: bounds[0] <= pwdata;
        REG_HUM_BOUNDS: bounds[1] <= pwdata;
        REG_DTEMP_BOUNDS: bounds[2] <= pwdata;
        REG_DHUM_BOUNDS: bounds[3] <= pwdata;
        REG_MEAN_BOUNDS: bounds[4] <= pwdata;
        REG_SDEV_BOUNDS: bounds[5] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RAW_MODE: prdata = {31'd0, raw_mode};
      REG_TEMP_BOUNDS: prdata = bounds[0];
      REG_HUM_BOUNDS: prdata = bounds[1];
      REG_DTEMP_BOUNDS: prdata = bounds[2];
      REG_DHUM_BOUNDS: prdata = bounds[3];
      REG_MEAN_BOUNDS: prdata = bounds[4];
      REG_SDEV_BOUNDS: prdata = bounds[5];
      default: prdata = '0;
    endcase
  end

  sfe_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign s_tready = (state == ST_IDLE) && !m_tvalid;

  // shared squarer operand
  always_comb begin
    mul_a = '0;
    if (idx < CountW'(WindowDepth)) begin
      mul_a = 18'(window[idx[SlotW-1:0]]);
    end
    if (state == ST_VAR) begin
      mul_a = acc_sum[17:0];
    end
  end
  assign mul_p = mul_a * mul_a;
  assign n_sumsq = acc_sq[30:0] * filled_count;
  assign n_sq = filled_count * filled_count;

  logic signed [15:0] b_lo, b_hi;
  assign b_lo = bounds[feat][15:0];
  assign b_hi = bounds[feat][31:16];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid && s_tready && !raw_mode) state_next = ST_ACC;
      ST_ACC: if (idx == filled_count - CountW'(1)) state_next = ST_VAR;
      ST_VAR: state_next = ST_DIV_MEAN;
      ST_DIV_MEAN: if (drsp.done) state_next = ST_DIV_VAR;
      ST_DIV_VAR: if (drsp.done) state_next = ST_SQRT;
      ST_SQRT: if (sq_bit == '0) state_next = ST_SCALE_SETUP;
      ST_SCALE_SETUP: state_next = (b_hi <= b_lo) ? ST_SCALE_DONE : ST_SCALE_DIV;
      ST_SCALE_DIV: if (drsp.done) state_next = ST_SCALE_DONE;
      ST_SCALE_DONE: state_next = (feat == 3'd5) ? ST_OUT : ST_SCALE_SETUP;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dreq = '0;
    if (state == ST_VAR) begin
      dreq.start = 1'b1;
      dreq.num = acc_sum[40] ? 41'(-acc_sum) : 41'(acc_sum);
      dreq.den = 41'(filled_count);
    end else if (state == ST_DIV_MEAN && drsp.done) begin
      dreq.start = 1'b1;
      dreq.num = acc_sq[40] ? '0 : acc_sq;
      dreq.den = 41'(n_sq);
    end else if (state == ST_SCALE_SETUP && !(b_hi <= b_lo)) begin
      dreq.start = 1'b1;
      dreq.num = snum[40] ? 41'(-snum) : 41'(snum);
      dreq.den = sden;
    end
  end

  assign snum = (41'(feat_v[feat]) - 41'(b_lo)) <<< 12;
  assign sden = 41'(17'(b_hi) - 17'(b_lo));
  assign neg = snum[40];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      write_slot <= '0;
      filled_count <= '0;
      prev_temperature <= '0;
      prev_humidity <= '0;
      have_previous <= 1'b0;
      raw_out <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            t_in <= 16'(signed'(s_tdata[14:0]));
            h_in <= {2'b00, s_tdata[28:15]};
            idx <= '0;
            acc_sum <= '0;
            acc_sq <= '0;
            if (raw_mode) begin
              res[0] <= 16'(signed'(s_tdata[14:0]));
              res[1] <= {2'b00, s_tdata[28:15]};
              for (int i = 2; i < 6; i++) res[i] <= '0;
              m_tvalid <= 1'b1;
            end else begin
              window[write_slot] <= 16'(signed'(s_tdata[14:0]));
              write_slot <= (write_slot == SlotW'(WindowDepth - 1)) ? '0
                                                                     : write_slot + SlotW'(1);
              if (filled_count < CountW'(WindowDepth))
                filled_count <= filled_count + CountW'(1);
              feat_v[2] <= have_previous ?
                17'(signed'(s_tdata[14:0])) - 17'(prev_temperature) : '0;
              feat_v[3] <= have_previous ?
                17'({3'b000, s_tdata[28:15]}) - 17'(prev_humidity) : '0;
              prev_temperature <= 16'(signed'(s_tdata[14:0]));
              prev_humidity <= {2'b00, s_tdata[28:15]};
              have_previous <= 1'b1;
            end
          end
        end
        ST_ACC: begin
          acc_sum <= acc_sum + 41'(mul_a);
          acc_sq <= acc_sq + 41'(mul_p);
          idx <= idx + CountW'(1);
        end
        ST_VAR: begin
          // n*sumsq - sum^2, sum squared on the shared squarer
          acc_sq <= 41'(n_sumsq) - 41'(mul_p);
        end
        ST_DIV_MEAN: begin
          if (drsp.done) mean <= acc_sum[40] ? -41'(drsp.quo) : 41'(drsp.quo);
        end
        ST_DIV_VAR: begin
          if (drsp.done) begin
            sq_x <= drsp.quo;
            sq_r <= '0;
            sq_bit <= 41'(1) << 40;
          end
        end
        ST_SQRT: begin
          if (sq_bit > sq_x && sq_r == '0) begin
            sq_bit <= sq_bit >> 2;
          end else if (sq_bit != '0) begin
            if (sq_x >= sq_r + sq_bit) begin
              sq_x <= sq_x - (sq_r + sq_bit);
              sq_r <= (sq_r >> 1) + sq_bit;
            end else begin
              sq_r <= sq_r >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
          if (sq_bit == '0) begin
            feat_v[0] <= 17'(t_in);
            feat_v[1] <= 17'(h_in);
            feat_v[4] <= 17'(mean);
            feat_v[5] <= 17'(sq_r);
            feat <= '0;
          end
        end
        ST_SCALE_SETUP: begin
          raw_out <= neg;
          if (b_hi <= b_lo) res[feat] <= '0;
        end
        ST_SCALE_DIV: begin
          if (drsp.done) begin
            logic signed [41:0] q;
            q = raw_out ? -(42'(drsp.quo) + ((drsp.rem != '0) ? 42'd1 : 42'd0))
                        : 42'(drsp.quo);
            if (q > 42'sd32767) res[feat] <= 16'sh7fff;
            else if (q < -42'sd32768) res[feat] <= 16'sh8000;
            else res[feat] <= q[15:0];
          end
        end
        ST_SCALE_DONE: feat <= feat + 3'd1;
        ST_OUT: m_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign m_tdata = {res[5], res[4], res[3], res[2], res[1], res[0]};

endmodule

// ===== design/sfe_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfe_checker
// port-level checks for the feature extractor
// ---------------------------------------------------------------------------
module sfe_checker import sfe_pkg::*; (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [95:0] m_tdata,
  input logic pready
);

  a_no_accept_while_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken with result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("ready right after item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result dropped or changed");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind sensor_feature_extractor sfe_checker u_sfe_checker (
  .clk (clk), .rst (rst), .s_tvalid (s_tvalid), .s_tready (s_tready),
  .m_tvalid (m_tvalid), .m_tready (m_tready), .m_tdata (m_tdata), .pready (pready)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// feature extractor check: bound and mode sweeps, random samples, random stalls
// ---------------------------------------------------------------------------
module tb_top;
  import sfe_pkg::*;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [31:0] s_tdata;    // temperature[14:0], humidity[28:15], zero pad
  logic m_tvalid;
  logic m_tready;
  logic [95:0] m_tdata;    // six 16-bit features, norm_temperature lowest
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  sensor_feature_extractor dut (.*);

  logic raw_q;
  logic [31:0] bnd_q [6];
  logic signed [15:0] win_q [WindowDepth];
  int slot_q;
  int fill_q;
  longint prev_t_q;
  longint prev_h_q;
  bit have_prev_q;

  logic [95:0] feature_fifo [$];
  int errors;
  bit rx_stall_en;
  bit tx_gap_en;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("FAIL sensor_feature_extractor");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic longint bound_scale(input longint v, input logic [31:0] r);
    longint lo, hi, num, den, q;
    lo = longint'($signed(r[15:0]));
    hi = longint'($signed(r[31:16]));
    if (hi <= lo) return 0;
    num = (v - lo) * 4096;
    den = hi - lo;
    q = num / den;
    if ((num % den) != 0 && num < 0) q -= 1;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic longint floor_sqrt(input longint x);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= x) r++;
    return r;
  endfunction

  function automatic logic [95:0] predict_features(input logic [14:0] tr,
                                                   input logic [13:0] hr);
    longint t, h, dt, dh, sum, sumsq, n, mean, num, var_v;
    longint f [6];
    logic [95:0] o;
    t = longint'($signed(tr));
    h = longint'(hr);
    o = '0;
    if (raw_q) begin
      o[15:0] = t[15:0];
      o[31:16] = h[15:0];
      return o;
    end
    dt = 0;
    dh = 0;
    if (have_prev_q) begin
      dt = t - prev_t_q;
      dh = h - prev_h_q;
    end
    win_q[slot_q] = t[15:0];
    slot_q = (slot_q + 1 >= WindowDepth) ? 0 : slot_q + 1;
    if (fill_q < WindowDepth) fill_q++;
    sum = 0;
    sumsq = 0;
    for (int i = 0; i < fill_q; i++) begin
      sum += longint'(win_q[i]);
      sumsq += longint'(win_q[i]) * longint'(win_q[i]);
    end
    n = fill_q;
    mean = sum / n;
    num = n * sumsq - sum * sum;
    if (num < 0) num = 0;
    var_v = num / (n * n);
    f[0] = bound_scale(t, bnd_q[0]);
    f[1] = bound_scale(h, bnd_q[1]);
    f[2] = bound_scale(dt, bnd_q[2]);
    f[3] = bound_scale(dh, bnd_q[3]);
    f[4] = bound_scale(mean, bnd_q[4]);
    f[5] = bound_scale(floor_sqrt(var_v), bnd_q[5]);
    prev_t_q = t;
    prev_h_q = h;
    have_prev_q = 1'b1;
    for (int i = 0; i < 6; i++) o[16*i +: 16] = f[i][15:0];
    return o;
  endfunction

  task automatic send_sample(input logic [14:0] t, input logic [13:0] h);
    if (tx_gap_en && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(posedge clk);
    s_tdata <= {3'b000, h, t};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    feature_fifo.push_back(predict_features(t, h));
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_RAW_MODE) raw_q = val[0];
    else if (idx <= REG_SDEV_BOUNDS) bnd_q[idx - 1] = val;
    @(posedge clk);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while (feature_fifo.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (500) @(posedge clk);
  endtask

  function automatic logic [14:0] rand_temp();
    return 15'($signed(-4000 + int'($urandom_range(0, 16500))));
  endfunction

  initial begin
    logic [95:0] exp_v;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (feature_fifo.size() == 0) report("result with nothing expected");
        else begin
          exp_v = feature_fifo.pop_front();
          for (int i = 0; i < 6; i++)
            if (m_tdata[16*i +: 16] !== exp_v[16*i +: 16])
              report($sformatf("feature %0d got %h want %h", i, m_tdata[16*i +: 16],
                               exp_v[16*i +: 16]));
        end
      end
      if (rx_stall_en && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic test_directed;
    send_sample(15'sd12500, 14'd10000);
    send_sample(-15'sd4000, 14'd0);
    send_sample(15'h7fff, 14'h3fff);
    send_sample(15'h4000, 14'h2000);
    send_sample(15'h0000, 14'h0000);
    send_sample(15'sd2500, 14'd5000);
    send_sample(15'sd2500, 14'd5000);
    drain();
  endtask

  task automatic test_bounds;
    logic [31:0] sets [4];
    sets[0] = 32'h0000_0000;
    sets[1] = 32'h7fff_8000;
    sets[2] = 32'h8000_7fff;
    sets[3] = 32'h0001_0000;
    foreach (sets[k]) begin
      for (int r = 1; r <= 6; r++) write_reg(3'(r), sets[k]);
      for (int i = 0; i < 3; i++) send_sample(rand_temp(), 14'($urandom_range(0, 10000)));
      send_sample(15'h7fff, 14'h3fff);
      drain();
    end
  endtask

  task automatic test_raw;
    write_reg(REG_RAW_MODE, 32'd1);
    send_sample(15'h4000, 14'h3fff);
    send_sample(15'h3fff, 14'd0);
    for (int i = 0; i < 20; i++) send_sample(15'($urandom), 14'($urandom));
    drain();
    write_reg(REG_RAW_MODE, 32'd0);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 90 == 0) begin
        drain();
        for (int r = 1; r <= 6; r++) begin
          int lo, span;
          lo = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 65535)) - 32768
                                         : int'($urandom_range(0, 12000)) - 4000;
          span = $urandom_range(1, 9000);
          if ($urandom_range(0, 9) == 0) write_reg(3'(r), $urandom);
          else write_reg(3'(r), {16'(lo + span), 16'(lo)});
        end
        write_reg(REG_RAW_MODE, 32'($urandom_range(0, 5) == 0));
      end
      if ($urandom_range(0, 9) == 0) send_sample(15'($urandom), 14'($urandom));
      else send_sample(rand_temp(), 14'($urandom_range(0, 10000)));
    end
    drain();
  endtask

  initial begin
    errors = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    raw_q = 1'b0;
    bnd_q[0] = TEMP_BOUNDS_RST;
    bnd_q[1] = HUM_BOUNDS_RST;
    bnd_q[2] = DTEMP_BOUNDS_RST;
    bnd_q[3] = DHUM_BOUNDS_RST;
    bnd_q[4] = MEAN_BOUNDS_RST;
    bnd_q[5] = SDEV_BOUNDS_RST;
    slot_q = 0;
    fill_q = 0;
    prev_t_q = 0;
    prev_h_q = 0;
    have_prev_q = 1'b0;
    rx_stall_en = 1'b1;
    tx_gap_en = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_bounds();
    test_raw();
    test_random(340);
    rx_stall_en = 1'b0;
    tx_gap_en = 1'b0;
    test_random(60);
    if (feature_fifo.size() != 0) report("results missing at end of run");
    if (errors == 0) $display("PASS sensor_feature_extractor");
    else $display("FAIL sensor_feature_extractor");
    $finish;
  end

endmodule
